### hw/rtl/vrt_pkg.sv
// ----------------------------------------------------------------------------
// vrt_pkg
// Shared types and constants for the value ramp timer.
// ----------------------------------------------------------------------------
package vrt_pkg;

    localparam int VALUE_W = 32;
    localparam int DUR_W   = 24;
    localparam int DELTA_W = 16;
    localparam int ACC_W   = 48;
    localparam int FRAC_SH = 15;

    // configuration register indexes
    localparam logic [1:0] CFG_START = 2'd0;
    localparam logic [1:0] CFG_END   = 2'd1;
    localparam logic [1:0] CFG_DUR   = 2'd2;
    localparam logic [1:0] CFG_CURVE = 2'd3;

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_TICK  = 2'd1,
        KIND_STOP  = 2'd2,
        KIND_CLEAR = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_START,
        OP_TICK,
        OP_STOP,
        OP_CLEAR,
        OP_DIV,
        OP_SET_STEP,
        OP_MUL_LO,
        OP_MUL_HI,
        OP_ACC_LIN,
        OP_TBL,
        OP_INTERP,
        OP_YSUM,
        OP_SPAN,
        OP_LOG_ACC
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_DIV,
        S_STEP,
        S_MUL_LO,
        S_MUL_HI,
        S_ACC_LIN,
        S_TBL,
        S_INTERP,
        S_YSUM,
        S_SPAN,
        S_LOG_ACC,
        S_RESULT
    } t_state;

    typedef struct packed {
        t_kind kind;
        logic  active;
        logic  dur_zero;
        logic  tick_end;
        logic  curve_log;
        logic  div_last;
        logic  out_free;
    } t_status;

    typedef struct packed {
        t_op  op;
        logic result;
    } t_cmd;

endpackage

### hw/rtl/value_ramp_timer_core.sv
// ----------------------------------------------------------------------------
// value_ramp_timer_core
// Ramp timer moving a Q16.16 value from a start to an end value over a
// programmed number of milliseconds, linear or logarithmic.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (i_kind, i_delta_ms) arrive on i_valid/o_ready: start, tick,
//   stop or clear-done. Every input word yields exactly one result word on
//   o_valid/i_ready, showing the state after the word has acted.
//   Configuration goes through i_cfg_we/i_cfg_idx/i_cfg_data while idle;
//   start, end and duration writes are dropped while the ramp runs.
//   One word is handled at a time. Stop, clear and ignored words go from
//   decode straight to the result step. A linear tick runs the low and high
//   multiplies and the accumulate. A start with a nonzero duration and a log
//   tick each run the shared one-bit-per-cycle divider over a quotient of
//   max(48, TIME_BITS + clog2(CURVE_ENTRIES) + 17) bits (49 at the
//   defaults); a start then sets the step, a log tick interpolates the curve.
//   The result sits in an output register; the next word is accepted while
//   it waits, and the sequencer holds in its result step while the receiver
//   stalls with the register still full.
//   A synchronous reset clears the ramp, the configuration registers and the result valid.
// ----------------------------------------------------------------------------
module value_ramp_timer_core #(
    parameter int TIME_BITS     = 24,
    parameter int CURVE_ENTRIES = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [1:0]                          i_kind,
    input  logic [vrt_pkg::DELTA_W-1:0]         i_delta_ms,
    input  logic                                i_cfg_we,
    input  logic [1:0]                          i_cfg_idx,
    input  logic [vrt_pkg::VALUE_W-1:0]         i_cfg_data,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [vrt_pkg::VALUE_W-1:0]  o_value,
    output logic signed [vrt_pkg::VALUE_W-1:0]  o_change,
    output logic                                o_running,
    output logic                                o_done_res,
    output logic [vrt_pkg::DUR_W-1:0]           o_elapsed_ms,
    output logic [vrt_pkg::DUR_W-1:0]           o_remaining_ms
);

    logic signed [vrt_pkg::VALUE_W-1:0] r_start_value;
    logic signed [vrt_pkg::VALUE_W-1:0] r_end_value;
    logic [vrt_pkg::DUR_W-1:0]          r_duration;
    logic                               r_curve_log;

    vrt_pkg::t_status status;
    vrt_pkg::t_cmd    cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_value <= '0;
            r_end_value   <= '0;
            r_duration    <= '0;
            r_curve_log   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                vrt_pkg::CFG_CURVE: r_curve_log <= i_cfg_data[0];
                vrt_pkg::CFG_START: begin
                    if (!status.active) r_start_value <= i_cfg_data;
                end
                vrt_pkg::CFG_END: begin
                    if (!status.active) r_end_value <= i_cfg_data;
                end
                vrt_pkg::CFG_DUR: begin
                    if (!status.active) r_duration <= i_cfg_data[vrt_pkg::DUR_W-1:0];
                end
                default: r_curve_log <= r_curve_log;
            endcase
        end
    end

    vrt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .i_status   (status),
        .o_in_ready (o_ready),
        .o_cmd      (cmd)
    );

    vrt_datapath #(
        .TIME_BITS     (TIME_BITS),
        .CURVE_ENTRIES (CURVE_ENTRIES)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_kind         (vrt_pkg::t_kind'(i_kind)),
        .i_delta_ms     (i_delta_ms),
        .i_start_value  (r_start_value),
        .i_end_value    (r_end_value),
        .i_duration_ms  (r_duration),
        .i_curve_log    (r_curve_log),
        .i_out_ready    (i_ready),
        .o_status       (status),
        .o_valid        (o_valid),
        .o_value        (o_value),
        .o_change       (o_change),
        .o_running      (o_running),
        .o_done_res     (o_done_res),
        .o_elapsed_ms   (o_elapsed_ms),
        .o_remaining_ms (o_remaining_ms)
    );

    // a ramp is never running and done at once
    a_run_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_running) |-> !o_done_res)
        else $error("running and done both set");

    // once time has passed on a running ramp the end has not been reached
    a_run_remaining: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_running && (o_elapsed_ms != '0)) |-> (o_remaining_ms != '0))
        else $error("running with no time remaining");

    a_idle_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_running) |-> (o_change == '0))
        else $error("change reported while not running");

    // one word in flight at a time
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("word accepted while busy");

endmodule

### hw/rtl/vrt_ctrl.sv
// ----------------------------------------------------------------------------
// vrt_ctrl
// Sequencer: steps the datapath through one input word at a time.
// ----------------------------------------------------------------------------
module vrt_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  vrt_pkg::t_status i_status,
    output logic             o_in_ready,
    output vrt_pkg::t_cmd    o_cmd
);

    vrt_pkg::t_state r_state;
    vrt_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vrt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            vrt_pkg::S_IDLE: begin
                if (i_in_valid) n_state = vrt_pkg::S_DECODE;
            end
            vrt_pkg::S_DECODE: begin
                n_state = vrt_pkg::S_RESULT;
                if (i_status.kind == vrt_pkg::KIND_START && !i_status.active) begin
                    if (!i_status.dur_zero) n_state = vrt_pkg::S_DIV;
                end else if (i_status.kind == vrt_pkg::KIND_TICK && i_status.active) begin
                    if (!i_status.tick_end) begin
                        n_state = i_status.curve_log ? vrt_pkg::S_DIV : vrt_pkg::S_MUL_LO;
                    end
                end
            end
            vrt_pkg::S_DIV: begin
                if (i_status.div_last) begin
                    n_state = (i_status.kind == vrt_pkg::KIND_START) ? vrt_pkg::S_STEP
                                                                     : vrt_pkg::S_TBL;
                end
            end
            vrt_pkg::S_STEP:    n_state = vrt_pkg::S_RESULT;
            vrt_pkg::S_MUL_LO:  n_state = vrt_pkg::S_MUL_HI;
            vrt_pkg::S_MUL_HI:  n_state = vrt_pkg::S_ACC_LIN;
            vrt_pkg::S_ACC_LIN: n_state = vrt_pkg::S_RESULT;
            vrt_pkg::S_TBL:     n_state = vrt_pkg::S_INTERP;
            vrt_pkg::S_INTERP:  n_state = vrt_pkg::S_YSUM;
            vrt_pkg::S_YSUM:    n_state = vrt_pkg::S_SPAN;
            vrt_pkg::S_SPAN:    n_state = vrt_pkg::S_LOG_ACC;
            vrt_pkg::S_LOG_ACC: n_state = vrt_pkg::S_RESULT;
            vrt_pkg::S_RESULT: begin
                if (i_status.out_free) n_state = vrt_pkg::S_IDLE;
            end
            default: n_state = vrt_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready    = 1'b0;
        o_cmd.op      = vrt_pkg::OP_NONE;
        o_cmd.result  = 1'b0;
        unique case (r_state)
            vrt_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_cmd.op = vrt_pkg::OP_LOAD;
            end
            vrt_pkg::S_DECODE: begin
                unique case (i_status.kind)
                    vrt_pkg::KIND_START: begin
                        if (!i_status.active) o_cmd.op = vrt_pkg::OP_START;
                    end
                    vrt_pkg::KIND_TICK: begin
                        if (i_status.active) o_cmd.op = vrt_pkg::OP_TICK;
                    end
                    vrt_pkg::KIND_STOP:  o_cmd.op = vrt_pkg::OP_STOP;
                    vrt_pkg::KIND_CLEAR: o_cmd.op = vrt_pkg::OP_CLEAR;
                    default:             o_cmd.op = vrt_pkg::OP_NONE;
                endcase
            end
            vrt_pkg::S_DIV:     o_cmd.op = vrt_pkg::OP_DIV;
            vrt_pkg::S_STEP:    o_cmd.op = vrt_pkg::OP_SET_STEP;
            vrt_pkg::S_MUL_LO:  o_cmd.op = vrt_pkg::OP_MUL_LO;
            vrt_pkg::S_MUL_HI:  o_cmd.op = vrt_pkg::OP_MUL_HI;
            vrt_pkg::S_ACC_LIN: o_cmd.op = vrt_pkg::OP_ACC_LIN;
            vrt_pkg::S_TBL:     o_cmd.op = vrt_pkg::OP_TBL;
            vrt_pkg::S_INTERP:  o_cmd.op = vrt_pkg::OP_INTERP;
            vrt_pkg::S_YSUM:    o_cmd.op = vrt_pkg::OP_YSUM;
            vrt_pkg::S_SPAN:    o_cmd.op = vrt_pkg::OP_SPAN;
            vrt_pkg::S_LOG_ACC: o_cmd.op = vrt_pkg::OP_LOG_ACC;
            vrt_pkg::S_RESULT:  o_cmd.result = i_status.out_free;
            default:            o_cmd.op = vrt_pkg::OP_NONE;
        endcase
    end

endmodule

### hw/rtl/vrt_datapath.sv
// ----------------------------------------------------------------------------
// vrt_datapath
// Ramp state, shared radix-2 divider, shared multiplier, curve table and
// the registered result word.
// ----------------------------------------------------------------------------
module vrt_datapath #(
    parameter int TIME_BITS     = 24,
    parameter int CURVE_ENTRIES = 256
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  vrt_pkg::t_cmd                        i_cmd,
    input  vrt_pkg::t_kind                       i_kind,
    input  logic        [vrt_pkg::DELTA_W-1:0]   i_delta_ms,
    input  logic signed [vrt_pkg::VALUE_W-1:0]   i_start_value,
    input  logic signed [vrt_pkg::VALUE_W-1:0]   i_end_value,
    input  logic        [vrt_pkg::DUR_W-1:0]     i_duration_ms,
    input  logic                                 i_curve_log,
    input  logic                                 i_out_ready,
    output vrt_pkg::t_status                     o_status,
    output logic                                 o_valid,
    output logic signed [vrt_pkg::VALUE_W-1:0]   o_value,
    output logic signed [vrt_pkg::VALUE_W-1:0]   o_change,
    output logic                                 o_running,
    output logic                                 o_done_res,
    output logic        [vrt_pkg::DUR_W-1:0]     o_elapsed_ms,
    output logic        [vrt_pkg::DUR_W-1:0]     o_remaining_ms
);

    localparam int IW = $clog2(CURVE_ENTRIES);
    localparam int CW = ((TIME_BITS > vrt_pkg::DUR_W) ? TIME_BITS : vrt_pkg::DUR_W) + 1;
    localparam int PW = TIME_BITS + IW + 17;
    localparam int NW = (PW > vrt_pkg::ACC_W) ? PW : vrt_pkg::ACC_W;
    localparam int KW = $clog2(NW);
    localparam int AW = vrt_pkg::ACC_W;
    localparam int HW = AW / 2;
    localparam logic [63:0] Q30_ONE = 64'd1 << 30;

    // log2 of a Q30 value in [1,16), result in Q.32 (elaboration only)
    function automatic logic [63:0] log2_q32(input logic [63:0] m_in);
        logic [63:0] m;
        logic [63:0] ip;
        logic [63:0] f;
        m  = m_in;
        ip = 64'd0;
        f  = 64'd0;
        for (int j = 0; j < 4; j++) begin
            if (m >= 2 * Q30_ONE) begin
                m  = m >> 1;
                ip = ip + 64'd1;
            end
        end
        for (int k = 0; k < 32; k++) begin
            m = (m * m) >> 30;
            f = f << 1;
            if (m >= 2 * Q30_ONE) begin
                m = m >> 1;
                f = f | 64'd1;
            end
        end
        return (ip << 32) | f;
    endfunction

    localparam logic [63:0] L11 = log2_q32(64'd11 << 30);

    typedef logic [15:0] t_curve [CURVE_ENTRIES];

    function automatic t_curve make_curve();
        t_curve      tbl;
        logic [63:0] v;
        logic [63:0] l;
        for (int i = 0; i < CURVE_ENTRIES; i++) begin
            v      = Q30_ONE + ((64'(10 * i)) << 30) / CURVE_ENTRIES;
            l      = log2_q32(v);
            tbl[i] = 16'((l * 64'd65536 + L11 / 2) / L11);
        end
        return tbl;
    endfunction

    localparam t_curve CURVE_TBL = make_curve();

    // state
    vrt_pkg::t_kind               r_kind;
    logic [vrt_pkg::DELTA_W-1:0]  r_delta;
    logic                         r_active;
    logic                         r_finished;
    logic [AW-1:0]                r_accum;
    logic [vrt_pkg::VALUE_W-1:0]  r_prior;
    logic [AW-1:0]                r_step;
    logic [TIME_BITS-1:0]         r_time;
    logic signed [32:0]           r_span;
    // divider
    logic [vrt_pkg::DUR_W:0]      r_rem;
    logic [NW-1:0]                r_quo;
    logic [vrt_pkg::DUR_W-1:0]    r_dsr;
    logic [KW-1:0]                r_cnt;
    logic                         r_neg;
    // curve interpolation / multiplier
    logic [16:0]                  r_t0;
    logic [16:0]                  r_t1;
    logic [15:0]                  r_frac;
    logic signed [17:0]           r_y;
    logic signed [51:0]           r_prod;
    logic [39:0]                  r_lo;
    // result word
    logic                         r_o_valid;
    logic [vrt_pkg::VALUE_W-1:0]  r_o_value;
    logic [vrt_pkg::VALUE_W-1:0]  r_o_change;
    logic                         r_o_running;
    logic                         r_o_done;
    logic [vrt_pkg::DUR_W-1:0]    r_o_elapsed;
    logic [vrt_pkg::DUR_W-1:0]    r_o_remaining;

    logic signed [32:0]           span_w;
    logic [32:0]                  span_mag;
    logic [CW:0]                  t_sum;
    logic [TIME_BITS-1:0]         t_new;
    logic                         tick_end;
    logic [vrt_pkg::DUR_W:0]      div_sh;
    logic                         div_bit;
    logic signed [33:0]           mul_a;
    logic signed [17:0]           mul_b;
    logic signed [51:0]           mul_p;
    logic signed [17:0]           t_diff;
    logic [NW-17:0]               pos_hi;
    logic [IW-1:0]                idx;
    logic [IW-1:0]                idx1;
    logic [vrt_pkg::VALUE_W-1:0]  cur_val;
    logic                         out_free;

    assign span_w   = 33'(i_end_value) - 33'(i_start_value);
    assign span_mag = span_w[32] ? 33'(-span_w) : 33'(span_w);

    // saturating elapsed time
    assign t_sum = (CW + 1)'(r_time) + (CW + 1)'(r_delta);
    assign t_new = (t_sum > (CW + 1)'({TIME_BITS{1'b1}})) ? {TIME_BITS{1'b1}}
                                                          : TIME_BITS'(t_sum);
    assign tick_end = CW'(t_new) >= CW'(i_duration_ms);

    // one restoring divide step per cycle
    assign div_sh  = {r_rem[vrt_pkg::DUR_W-1:0], r_quo[NW-1]};
    assign div_bit = div_sh >= {1'b0, r_dsr};

    assign t_diff = 18'(r_t1) - 18'(r_t0);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.op)
            vrt_pkg::OP_MUL_LO: begin
                mul_a = {10'd0, r_step[HW-1:0]};
                mul_b = {2'd0, r_delta};
            end
            vrt_pkg::OP_MUL_HI: begin
                mul_a = {{10{r_step[AW-1]}}, r_step[AW-1:HW]};
                mul_b = {2'd0, r_delta};
            end
            vrt_pkg::OP_INTERP: begin
                mul_a = {{16{t_diff[17]}}, t_diff};
                mul_b = {2'd0, r_frac};
            end
            vrt_pkg::OP_SPAN: begin
                mul_a = {r_span[32], r_span};
                mul_b = r_y;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign pos_hi = r_quo[NW-1:16];
    assign idx    = (pos_hi >= (NW - 16)'(CURVE_ENTRIES)) ? IW'(CURVE_ENTRIES - 1)
                                                          : IW'(pos_hi);
    assign idx1   = (idx == IW'(CURVE_ENTRIES - 1)) ? idx : IW'(idx + 1'b1);

    assign cur_val  = r_accum[vrt_pkg::FRAC_SH +: vrt_pkg::VALUE_W];
    assign out_free = !r_o_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_finished <= 1'b0;
            r_time     <= '0;
            r_accum    <= '0;
            r_prior    <= '0;
            r_step     <= '0;
            r_cnt      <= '0;
            r_kind     <= vrt_pkg::KIND_START;
        end else begin
            case (i_cmd.op)
                vrt_pkg::OP_LOAD: begin
                    r_kind  <= i_kind;
                    r_delta <= i_delta_ms;
                end
                vrt_pkg::OP_START: begin
                    r_time     <= '0;
                    r_accum    <= AW'({i_start_value, {vrt_pkg::FRAC_SH{1'b0}}})
                                  | {{(AW - vrt_pkg::VALUE_W - vrt_pkg::FRAC_SH)
                                      {i_start_value[vrt_pkg::VALUE_W-1]}},
                                     {(vrt_pkg::VALUE_W + vrt_pkg::FRAC_SH){1'b0}}};
                    r_prior    <= i_start_value;
                    r_step     <= '0;
                    r_active   <= 1'b1;
                    r_finished <= 1'b0;
                    r_span     <= span_w;
                    r_rem      <= '0;
                    r_quo      <= NW'({span_mag, {vrt_pkg::FRAC_SH{1'b0}}});
                    r_dsr      <= i_duration_ms;
                    r_neg      <= span_w[32];
                    r_cnt      <= '0;
                end
                vrt_pkg::OP_TICK: begin
                    if (tick_end) begin
                        r_time     <= TIME_BITS'(i_duration_ms);
                        r_accum    <= AW'({i_end_value, {vrt_pkg::FRAC_SH{1'b0}}})
                                      | {{(AW - vrt_pkg::VALUE_W - vrt_pkg::FRAC_SH)
                                          {i_end_value[vrt_pkg::VALUE_W-1]}},
                                         {(vrt_pkg::VALUE_W + vrt_pkg::FRAC_SH){1'b0}}};
                        r_prior    <= i_end_value;
                        r_active   <= 1'b0;
                        r_finished <= 1'b1;
                    end else begin
                        r_prior <= cur_val;
                        r_time  <= t_new;
                        // curve position numerator: t * N * 2^16
                        r_quo   <= (NW'(t_new) * NW'(CURVE_ENTRIES)) << 16;
                        r_rem   <= '0;
                        r_dsr   <= i_duration_ms;
                        r_neg   <= 1'b0;
                        r_cnt   <= '0;
                    end
                end
                vrt_pkg::OP_STOP:  r_active   <= 1'b0;
                vrt_pkg::OP_CLEAR: r_finished <= 1'b0;
                vrt_pkg::OP_DIV: begin
                    r_rem <= div_bit ? (div_sh - {1'b0, r_dsr}) : div_sh;
                    r_quo <= {r_quo[NW-2:0], div_bit};
                    r_cnt <= KW'(r_cnt + 1'b1);
                end
                vrt_pkg::OP_SET_STEP: begin
                    r_step <= r_neg ? AW'(-r_quo[AW-1:0]) : r_quo[AW-1:0];
                end
                vrt_pkg::OP_MUL_LO: r_prod <= mul_p;
                vrt_pkg::OP_MUL_HI: begin
                    r_lo   <= r_prod[39:0];
                    r_prod <= mul_p;
                end
                vrt_pkg::OP_ACC_LIN: begin
                    r_accum <= r_accum + {r_prod[AW-HW-1:0], {HW{1'b0}}}
                               + {{(AW - 40){1'b0}}, r_lo};
                end
                vrt_pkg::OP_TBL: begin
                    r_t0   <= {1'b0, CURVE_TBL[idx]};
                    r_t1   <= (idx == IW'(CURVE_ENTRIES - 1)) ? 17'd65536
                                                              : {1'b0, CURVE_TBL[idx1]};
                    r_frac <= r_quo[15:0];
                end
                vrt_pkg::OP_INTERP: r_prod <= mul_p;
                vrt_pkg::OP_YSUM: begin
                    r_y <= 18'(r_t0) + 18'(r_prod >>> 16);
                end
                vrt_pkg::OP_SPAN: r_prod <= mul_p;
                vrt_pkg::OP_LOG_ACC: begin
                    r_accum <= AW'(signed'({i_start_value, {vrt_pkg::FRAC_SH{1'b0}}}))
                               + AW'(r_prod >>> 1);
                end
                default: begin
                    r_active <= r_active;
                end
            endcase
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.result) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.result) begin
            r_o_value     <= r_active ? cur_val : i_start_value;
            r_o_change    <= r_active ? (cur_val - r_prior) : '0;
            r_o_running   <= r_active;
            r_o_done      <= r_finished;
            r_o_elapsed   <= vrt_pkg::DUR_W'(r_time);
            r_o_remaining <= (CW'(i_duration_ms) > CW'(r_time))
                             ? vrt_pkg::DUR_W'(CW'(i_duration_ms) - CW'(r_time)) : '0;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_value        = r_o_value;
    assign o_change       = r_o_change;
    assign o_running      = r_o_running;
    assign o_done_res     = r_o_done;
    assign o_elapsed_ms   = r_o_elapsed;
    assign o_remaining_ms = r_o_remaining;

    assign o_status.kind      = r_kind;
    assign o_status.active    = r_active;
    assign o_status.dur_zero  = (i_duration_ms == '0);
    assign o_status.tick_end  = tick_end;
    assign o_status.curve_log = i_curve_log;
    assign o_status.div_last  = (r_cnt == KW'(NW - 1));
    assign o_status.out_free  = out_free;

endmodule
